FILE: rtl/egcd_pkg.sv
// Shared types and codes for the extended gcd / modular inverse unit.
// No dependencies.
package egcd_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] REQ_GCD = 2'd0;
  localparam logic [1:0] REQ_EXT = 2'd1;
  localparam logic [1:0] REQ_INV = 2'd2;

  // Status codes carried on out_tuser.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_INV   = 2'd1;
  localparam logic [1:0] STATUS_ZERO_MOD = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH,
    ST_MDIV,
    ST_MFIX
  } egcd_state_t;

endpackage

FILE: rtl/extended_gcd_mod_inverse_unit.sv
// Extended Euclid unit: gcd, Bezout coefficients and modular inverse.
// Depends on egcd_pkg (request, status and state codes).
//
// Each Euclid step runs a check, the bit-serial restoring divider and an
// update; a modular inverse adds a final reduction of x modulo b on the
// same divider. One transaction in flight at a time; in_tready is high only
// while the sequencer is idle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
module extended_gcd_mod_inverse_unit import egcd_pkg::*; #(
  parameter int WORD_BITS = 32,
  localparam int IN_BITS  = ((2 * WORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = ((3 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_BITS-1:0]  in_tdata,   // operand_a, operand_b (low to high)
  input  logic [1:0]          in_tuser,   // req_type
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_BITS-1:0] out_tdata,  // result_value, coef_x, coef_y (low to high)
  output logic [1:0]          out_tuser   // status
);

  localparam int W        = WORD_BITS;
  localparam int CNT_BITS = $clog2(WORD_BITS + 1);
  localparam logic [CNT_BITS-1:0] CNT_LOAD = CNT_BITS'(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(1);
  localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] SAT_NEG  = {1'b1, {(W-2){1'b0}}, 1'b1};
  localparam logic signed [W-1:0] ONE      = W'(1);
  localparam logic signed [W-1:0] MINUS1   = {W{1'b1}};

  egcd_state_t state_r, state_nxt;

  // Euclid state: remainders r, coefficient pairs s (for a) and t (for b).
  logic signed [W-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic signed [W-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic signed [W-1:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic signed [W-1:0] b_r, b_nxt;          // modulus kept for the inverse
  logic [1:0]          req_r, req_nxt;

  // Shared bit-serial divider; quotient bits also drive Horner products q*s1, q*t1.
  logic [W-1:0]        quo_r, quo_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        dvs_r, dvs_nxt;
  logic signed [W+1:0] ps_r, ps_nxt, pt_r, pt_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] out_res_r, out_res_nxt;
  logic signed [W-1:0] out_x_r, out_x_nxt;
  logic signed [W-1:0] out_y_r, out_y_nxt;
  logic [1:0]          out_st_r, out_st_nxt;

  logic                in_fire, out_free;
  logic signed [W-1:0] op_a, op_b;
  logic [W+1:0]        div_shift, div_diff;
  logic                qbit;
  logic [W-1:0]        r0_mag, r1_mag, s0_mag, b_mag;
  logic signed [W-1:0] rem_signed, d_abs;
  logic                q_neg;
  logic signed [W:0]   m_val, v_val;
  logic [W:0]          v_mag;
  logic signed [W:0]   inv_val;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Saturate the most negative code so magnitudes fit in W-1 bits.
  assign op_a = (in_tdata[W-1:0] == MOST_NEG) ? SAT_NEG : in_tdata[W-1:0];
  assign op_b = (in_tdata[2*W-1:W] == MOST_NEG) ? SAT_NEG : in_tdata[2*W-1:W];

  assign r0_mag = r0_r[W-1] ? W'(-r0_r) : W'(r0_r);
  assign r1_mag = r1_r[W-1] ? W'(-r1_r) : W'(r1_r);
  assign s0_mag = s0_r[W-1] ? W'(-s0_r) : W'(s0_r);
  assign b_mag  = b_r[W-1]  ? W'(-b_r)  : W'(b_r);
  assign d_abs  = r0_r[W-1] ? -r0_r : r0_r;

  // One restoring-division step: remainder stays below the divisor (< 2^(W-1)).
  assign div_shift = {1'b0, rem_r, quo_r[W-1]};
  assign div_diff  = div_shift - {2'b00, dvs_r};
  assign qbit      = !div_diff[W+1];

  // Truncating division: remainder takes the dividend's sign.
  assign rem_signed = r0_r[W-1] ? -$signed(rem_r) : $signed(rem_r);
  assign q_neg      = r0_r[W-1] ^ r1_r[W-1];

  // Inverse fix-up: ((x % b) + b) % b, with |x % b + b| < 2|b|.
  assign m_val   = s0_r[W-1] ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
  assign v_val   = m_val + (W+1)'(b_r);
  assign v_mag   = v_val[W] ? (W+1)'(-v_val) : (W+1)'(v_val);
  assign inv_val = (v_mag < {1'b0, b_mag}) ? v_val
                 : (v_val[W] ? v_val + $signed({1'b0, b_mag})
                             : v_val - $signed({1'b0, b_mag}));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = (r1_r == '0) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_CHECK;
      end
      ST_FINISH: begin
        if (req_r == REQ_INV && r0_r == ONE && b_r != '0) begin
          state_nxt = ST_MDIV;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MDIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_MFIX;
      end
      ST_MFIX: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    r0_nxt  = r0_r;
    r1_nxt  = r1_r;
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    t0_nxt  = t0_r;
    t1_nxt  = t1_r;
    b_nxt   = b_r;
    req_nxt = req_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    ps_nxt  = ps_r;
    pt_nxt  = pt_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_st_nxt    = out_st_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          r0_nxt  = op_a;
          r1_nxt  = op_b;
          b_nxt   = op_b;
          s0_nxt  = ONE;
          s1_nxt  = '0;
          t0_nxt  = '0;
          t1_nxt  = ONE;
          req_nxt = in_tuser;
        end
      end
      ST_CHECK: begin
        quo_nxt = r0_mag;
        rem_nxt = '0;
        dvs_nxt = r1_mag;
        ps_nxt  = '0;
        pt_nxt  = '0;
        cnt_nxt = CNT_LOAD;
      end
      ST_DIV, ST_MDIV: begin
        quo_nxt = {quo_r[W-2:0], qbit};
        rem_nxt = qbit ? div_diff[W-1:0] : div_shift[W-1:0];
        ps_nxt  = (ps_r <<< 1) + (qbit ? (W+2)'(s1_r) : '0);
        pt_nxt  = (pt_r <<< 1) + (qbit ? (W+2)'(t1_r) : '0);
        cnt_nxt = cnt_r - CNT_LAST;
      end
      ST_UPDATE: begin
        r0_nxt = r1_r;
        r1_nxt = rem_signed;
        s0_nxt = s1_r;
        s1_nxt = q_neg ? s0_r + ps_r[W-1:0] : s0_r - ps_r[W-1:0];
        t0_nxt = t1_r;
        t1_nxt = q_neg ? t0_r + pt_r[W-1:0] : t0_r - pt_r[W-1:0];
      end
      ST_FINISH: begin
        if (req_r == REQ_INV && r0_r == ONE && b_r != '0) begin
          // Reduce x modulo b on the shared divider.
          quo_nxt = s0_mag;
          rem_nxt = '0;
          dvs_nxt = b_mag;
          ps_nxt  = '0;
          pt_nxt  = '0;
          cnt_nxt = CNT_LOAD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_st_nxt    = STATUS_OK;
          unique case (req_r)
            REQ_GCD: out_res_nxt = d_abs;
            REQ_EXT: begin
              out_res_nxt = d_abs;
              out_x_nxt   = s0_r;
              out_y_nxt   = t0_r;
            end
            REQ_INV: begin
              if (r0_r != ONE) begin
                out_res_nxt = MINUS1;
                out_st_nxt  = STATUS_NO_INV;
              end else begin
                out_res_nxt = '0;
                out_st_nxt  = STATUS_ZERO_MOD;
              end
            end
            default: out_res_nxt = '0;
          endcase
        end
      end
      ST_MFIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = inv_val[W-1:0];
          out_x_nxt     = '0;
          out_y_nxt     = '0;
          out_st_nxt    = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    s0_r      <= s0_nxt;
    s1_r      <= s1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    b_r       <= b_nxt;
    req_r     <= req_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    ps_r      <= ps_nxt;
    pt_r      <= pt_nxt;
    out_res_r <= out_res_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_y_r, out_x_r, out_res_r});
  assign out_tuser  = out_st_r;

endmodule
